// ----- hdl/plql_pkg.sv -----
// shared constants, types and codes for the two-class priority linked queue
package plql_pkg;

  localparam int unsigned POOL_NODES = 64;
  localparam int unsigned DATA_WIDTH = 32;

  // port widths fixed by the interface
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned ITEMS_W  = 7;
  localparam int unsigned STATUS_W = 2;

  // derived widths
  localparam int unsigned NODE_W  = $clog2(POOL_NODES);
  localparam int unsigned COUNT_W = $clog2(POOL_NODES + 1);
  localparam int unsigned STORE_W = (DATA_WIDTH < ITEM_W) ? DATA_WIDTH : ITEM_W;

  // operation codes
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef logic [NODE_W-1:0] node_t;

  // access request to the link store
  typedef struct packed {
    logic  we;
    node_t waddr;
    node_t wdata;
    logic  re;
    node_t raddr;
  } link_req_t;

endpackage

// ----- hdl/plql_ram.sv -----
// generic single write port, single read port ram with registered read
module plql_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/plql_link_store.sv -----
// next-link memory with per-entry valid bits that stand in for the reset chain
module plql_link_store import plql_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  link_req_t req_i,
  output node_t     rdata_o
);

  logic [POOL_NODES-1:0] valid_q, valid_d;
  node_t                 raddr_q;
  node_t                 ram_rdata;
  node_t                 dflt_link;

  plql_ram #(
    .WIDTH (NODE_W),
    .DEPTH (POOL_NODES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.we),
    .waddr_i (req_i.waddr),
    .wdata_i (req_i.wdata),
    .re_i    (req_i.re),
    .raddr_i (req_i.raddr),
    .rdata_o (ram_rdata)
  );

  // mark entries once written
  always_comb begin
    valid_d = valid_q;
    if (req_i.we) begin
      valid_d[req_i.waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // keep the read address for the reset-value path
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      raddr_q <= req_i.raddr;
    end
  end

  // an unwritten entry links to the following node, wrapping at the pool end
  assign dflt_link = (raddr_q == NODE_W'(POOL_NODES - 1)) ? '0 : raddr_q + 1'b1;
  assign rdata_o   = valid_q[raddr_q] ? ram_rdata : dflt_link;

endmodule

// ----- hdl/two_class_priority_linked_queue_top.sv -----
// two-class priority queue over a shared linked node pool, top level
// result: a command taken moves the sequencer to its exec state, whose end
//   registers the result word, held for one cycle with result_valid_o high;
//   the receiver cannot stall
// issue: busy stays high in the exec state, so no new command is taken before
//   the registered link memory read has given the new head or free head
// reset: queues empty, free list chained in node order; no clearing pass
module two_class_priority_linked_queue_top import plql_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                func_i,
  input  logic [ITEM_W-1:0]   item_data_i,
  input  logic                out_of_band_i,
  output logic                result_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [ITEM_W-1:0]   dequeued_data_o,
  output logic                from_priority_o,
  output logic [ITEMS_W-1:0]  items_held_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic accept;

  logic func_q;

  node_t norm_head_q, norm_head_d, norm_tail_q, norm_tail_d;
  node_t prio_head_q, prio_head_d, prio_tail_q, prio_tail_d;
  logic  norm_ne_q, norm_ne_d, prio_ne_q, prio_ne_d;
  node_t free_head_q, free_head_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic  oob_q;

  logic pool_full;
  logic both_empty;

  link_req_t          link_req;
  node_t              link_rdata;
  logic [STORE_W-1:0] pay_rdata;
  node_t              deq_addr;

  logic                res_valid_q;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [ITEM_W-1:0]   res_data_q, res_data_d;
  logic                res_prio_q, res_prio_d;
  logic [ITEMS_W-1:0]  res_items_q;

  assign busy   = (state_q == ST_EXEC);
  assign accept = start && !busy;

  assign pool_full  = (count_q >= COUNT_W'(POOL_NODES));
  assign both_empty = !prio_ne_q && !norm_ne_q;
  assign deq_addr   = prio_ne_q ? prio_head_q : norm_head_q;

  // payload store: written on an accepted enqueue when the pool is not full, read for a dequeue
  plql_ram #(
    .WIDTH (STORE_W),
    .DEPTH (POOL_NODES)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (accept && (func_i == FUNC_ENQ) && !pool_full),
    .waddr_i (free_head_q),
    .wdata_i (item_data_i[STORE_W-1:0]),
    .re_i    (accept && (func_i == FUNC_DEQ)),
    .raddr_i (deq_addr),
    .rdata_o (pay_rdata)
  );

  plql_link_store u_link_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (link_req),
    .rdata_o (link_rdata)
  );

  // command latch
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      oob_q  <= out_of_band_i;
    end
  end

  // sequencer, link requests and pointer updates
  always_comb begin
    state_d      = state_q;
    norm_head_d  = norm_head_q;
    norm_tail_d  = norm_tail_q;
    norm_ne_d    = norm_ne_q;
    prio_head_d  = prio_head_q;
    prio_tail_d  = prio_tail_q;
    prio_ne_d    = prio_ne_q;
    free_head_d  = free_head_q;
    count_d      = count_q;
    res_status_d = STATUS_DONE;
    res_data_d   = '0;
    res_prio_d   = 1'b0;
    link_req     = '0;

    // read phase: fetch the link after the free head or the queue head
    link_req.re    = accept;
    link_req.raddr = (func_i == FUNC_ENQ) ? free_head_q : deq_addr;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        if (func_q == FUNC_ENQ) begin
          if (pool_full) begin
            res_status_d = STATUS_FULL;
          end else begin
            free_head_d = link_rdata;
            count_d     = count_q + 1'b1;
            if (oob_q) begin
              if (prio_ne_q) begin
                link_req.we    = 1'b1;
                link_req.waddr = prio_tail_q;
                link_req.wdata = free_head_q;
              end else begin
                prio_head_d = free_head_q;
                prio_ne_d   = 1'b1;
              end
              prio_tail_d = free_head_q;
            end else begin
              if (norm_ne_q) begin
                link_req.we    = 1'b1;
                link_req.waddr = norm_tail_q;
                link_req.wdata = free_head_q;
              end else begin
                norm_head_d = free_head_q;
                norm_ne_d   = 1'b1;
              end
              norm_tail_d = free_head_q;
            end
          end
        end else begin
          if (both_empty) begin
            res_status_d = STATUS_EMPTY;
          end else begin
            // freed node goes to the front of the free list
            link_req.we    = 1'b1;
            link_req.waddr = deq_addr;
            link_req.wdata = free_head_q;
            free_head_d    = deq_addr;
            if (count_q != '0) begin
              count_d = count_q - 1'b1;
            end
            res_data_d = ITEM_W'(pay_rdata);
            if (prio_ne_q) begin
              res_prio_d = 1'b1;
              if (prio_head_q == prio_tail_q) begin
                prio_ne_d = 1'b0;
              end else begin
                prio_head_d = link_rdata;
              end
            end else begin
              if (norm_head_q == norm_tail_q) begin
                norm_ne_d = 1'b0;
              end else begin
                norm_head_d = link_rdata;
              end
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      norm_head_q <= '0;
      norm_tail_q <= '0;
      norm_ne_q   <= 1'b0;
      prio_head_q <= '0;
      prio_tail_q <= '0;
      prio_ne_q   <= 1'b0;
      free_head_q <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      norm_head_q <= norm_head_d;
      norm_tail_q <= norm_tail_d;
      norm_ne_q   <= norm_ne_d;
      prio_head_q <= prio_head_d;
      prio_tail_q <= prio_tail_d;
      prio_ne_q   <= prio_ne_d;
      free_head_q <= free_head_d;
      count_q     <= count_d;
      res_valid_q <= (state_q == ST_EXEC);
    end
  end

  // result word register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      res_status_q <= res_status_d;
      res_data_q   <= res_data_d;
      res_prio_q   <= res_prio_d;
      res_items_q  <= ITEMS_W'(count_d);
    end
  end

  assign result_valid_o  = res_valid_q;
  assign status_o        = res_status_q;
  assign dequeued_data_o = res_data_q;
  assign from_priority_o = res_prio_q;
  assign items_held_o    = res_items_q;

endmodule

// ----- bench/two_class_priority_linked_queue_top_tb.sv -----
// self-checking bench for the two-class priority linked queue: directed words, then random bursts
module two_class_priority_linked_queue_top_tb;
  import plql_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WORD_TOTAL  = 1150;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // one expected result word
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ITEM_W-1:0]   data;
    logic                prio;
    logic [ITEMS_W-1:0]  held;
  } queue_word_t;

  // predicts the shared node pool and holds the result words still to come
  class linked_queue_checker;
    logic [ITEM_W-1:0] slot_data [POOL_NODES];
    node_t             slot_link [POOL_NODES];
    node_t             norm_head, norm_tail, prio_head, prio_tail, free_head;
    bit                norm_live, prio_live;
    int unsigned       held_count;
    queue_word_t       awaited_words [$];
    int unsigned       errors;

    function new();
      for (int i = 0; i < POOL_NODES; i++) begin
        slot_data[i] = '0;
        slot_link[i] = node_t'(i + 1);
      end
      norm_head  = '0;
      norm_tail  = '0;
      prio_head  = '0;
      prio_tail  = '0;
      free_head  = '0;
      norm_live  = 1'b0;
      prio_live  = 1'b0;
      held_count = 0;
      errors     = 0;
    endfunction

    // works out the result word of an accepted command and updates the pool
    function void note_command(logic f, logic [ITEM_W-1:0] d, logic oob);
      queue_word_t       w;
      node_t             node;
      logic [ITEM_W-1:0] stored;
      w.status = STATUS_DONE;
      w.data   = '0;
      w.prio   = 1'b0;
      if (f == FUNC_ENQ) begin
        if (held_count >= POOL_NODES) begin
          w.status = STATUS_FULL;
        end else begin
          node      = free_head;
          free_head = slot_link[node];
          stored    = '0;
          stored[STORE_W-1:0] = d[STORE_W-1:0];
          slot_data[node] = stored;
          if (oob) begin
            if (prio_live) begin
              slot_link[prio_tail] = node;
              prio_tail = node;
            end else begin
              prio_head = node;
              prio_tail = node;
              prio_live = 1'b1;
            end
          end else begin
            if (norm_live) begin
              slot_link[norm_tail] = node;
              norm_tail = node;
            end else begin
              norm_head = node;
              norm_tail = node;
              norm_live = 1'b1;
            end
          end
          held_count++;
        end
      end else begin
        if (prio_live) begin
          node = prio_head;
          if (prio_head == prio_tail) prio_live = 1'b0;
          else prio_head = slot_link[node];
          w.prio = 1'b1;
        end else if (norm_live) begin
          node = norm_head;
          if (norm_head == norm_tail) norm_live = 1'b0;
          else norm_head = slot_link[node];
        end else begin
          w.status = STATUS_EMPTY;
        end
        if (w.status == STATUS_DONE) begin
          w.data = slot_data[node];
          slot_link[node] = free_head;
          free_head = node;
          if (held_count > 0) held_count--;
        end
      end
      w.held = ITEMS_W'(held_count);
      awaited_words.push_back(w);
    endfunction

    // compares a result word with the oldest one expected
    function void check_result(logic [STATUS_W-1:0] st, logic [ITEM_W-1:0] d, logic p,
                               logic [ITEMS_W-1:0] h);
      queue_word_t w;
      if (awaited_words.size() == 0) begin
        $error("result word with none expected: status %0d data 0x%08h", st, d);
        errors++;
        return;
      end
      w = awaited_words.pop_front();
      if (st !== w.status) begin
        $error("status: expected %0d, got %0d", w.status, st);
        errors++;
      end
      if (d !== w.data) begin
        $error("dequeued_data: expected 0x%08h, got 0x%08h", w.data, d);
        errors++;
      end
      if (p !== w.prio) begin
        $error("from_priority: expected %0d, got %0d", w.prio, p);
        errors++;
      end
      if (h !== w.held) begin
        $error("items_held: expected %0d, got %0d", w.held, h);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return awaited_words.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                func_i;
  logic [ITEM_W-1:0]   item_data_i;
  logic                out_of_band_i;
  logic                result_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [ITEM_W-1:0]   dequeued_data_o;
  logic                from_priority_o;
  logic [ITEMS_W-1:0]  items_held_o;

  linked_queue_checker queue_check = new();
  int unsigned         words_sent;
  int unsigned         cycle_count;

  two_class_priority_linked_queue_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .item_data_i    (item_data_i),
    .out_of_band_i  (out_of_band_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .dequeued_data_o(dequeued_data_o),
    .from_priority_o(from_priority_o),
    .items_held_o   (items_held_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // result words are taken at the edge that ends their strobe cycle
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      queue_check.check_result(status_o, dequeued_data_o, from_priority_o, items_held_o);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // waits the idle gap, presents one command word and holds it until taken
  task automatic issue_command(input logic f, input logic [ITEM_W-1:0] d, input logic oob,
                               input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    func_i        <= f;
    item_data_i   <= d;
    out_of_band_i <= oob;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    queue_check.note_command(f, d, oob);
    words_sent++;
  endtask

  function automatic int unsigned draw_gap(bit idle_on);
    return idle_on ? $urandom_range(0, 4) : 0;
  endfunction

  // one burst of random commands with a given enqueue share and priority share
  task automatic run_burst(input int unsigned enq_pct, input int unsigned oob_pct,
                           input int unsigned len, input bit idle_on);
    logic f;
    for (int i = 0; i < len; i++) begin
      f = ($urandom_range(1, 100) <= enq_pct) ? FUNC_ENQ : FUNC_DEQ;
      issue_command(f, $urandom(), $urandom_range(1, 100) <= oob_pct, draw_gap(idle_on));
    end
  endtask

  initial begin
    int unsigned enq_pct;
    int unsigned drain_wait;
    cycle_count   = 0;
    words_sent    = 0;
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    func_i        <= FUNC_ENQ;
    item_data_i   <= '0;
    out_of_band_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty refusal, field extremes, priority order, single-item queues
    issue_command(FUNC_DEQ, 32'h0000_0000, 1'b0, 1);
    issue_command(FUNC_ENQ, 32'h0000_0000, 1'b0, 0);
    issue_command(FUNC_ENQ, 32'hFFFF_FFFF, 1'b0, 0);
    issue_command(FUNC_ENQ, 32'hA5A5_A5A5, 1'b1, 2);
    issue_command(FUNC_ENQ, 32'h5A5A_5A5A, 1'b1, 0);
    issue_command(FUNC_DEQ, 32'hFFFF_FFFF, 1'b1, 0);
    issue_command(FUNC_ENQ, 32'h1234_5678, 1'b0, 1);
    issue_command(FUNC_DEQ, 32'h0000_0000, 1'b0, 3);
    issue_command(FUNC_DEQ, 32'h0000_0000, 1'b0, 0);
    issue_command(FUNC_DEQ, 32'h0000_0000, 1'b1, 4);
    issue_command(FUNC_DEQ, 32'h0000_0000, 1'b0, 0);
    issue_command(FUNC_DEQ, 32'hFFFF_FFFF, 1'b1, 0);
    issue_command(FUNC_ENQ, 32'h8000_0001, 1'b1, 0);
    issue_command(FUNC_ENQ, 32'h7FFF_FFFE, 1'b0, 0);
    issue_command(FUNC_DEQ, 32'h0000_0000, 1'b0, 0);
    issue_command(FUNC_DEQ, 32'h0000_0000, 1'b0, 2);
    issue_command(FUNC_DEQ, 32'h0000_0000, 1'b0, 0);

    // fill the pool past full, with rejections on both classes, then drain past empty
    run_burst(100, 50, POOL_NODES + 6, 1'b0);
    run_burst(0, 50, POOL_NODES + 4, 1'b1);

    // random bursts, from drain-heavy to fill-heavy, with and without idling
    while (words_sent < WORD_TOTAL) begin
      case ($urandom_range(0, 4))
        0: enq_pct = 0;
        1: enq_pct = 30;
        2: enq_pct = 50;
        3: enq_pct = 75;
        default: enq_pct = 100;
      endcase
      run_burst(enq_pct, $urandom_range(0, 100), $urandom_range(10, 80),
                $urandom_range(0, 3) != 0);
    end
    start <= 1'b0;

    // let the last result words arrive, then watch for strays
    drain_wait = 0;
    while (queue_check.outstanding() != 0 && drain_wait < 1000) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (8) @(posedge clk_i);
    if (queue_check.errors == 0 && queue_check.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      if (queue_check.outstanding() != 0) begin
        $error("%0d result words never arrived", queue_check.outstanding());
      end
      $display("FAILURE");
    end
    $finish;
  end

endmodule
